/* rtl/core/lbpd_pkg.sv */
// Package with the request types, mode codes and command codes of the LCD bus pixel decoder.
package lbpd_pkg;

    typedef enum logic [1:0] {
        MODE_IDLE    = 2'd0,
        MODE_LATCH   = 2'd1,
        MODE_DISPLAY = 2'd2
    } t_mode;

    localparam logic [6:0] CMD_LINE_LATCH = 7'h75;
    localparam logic [6:0] CMD_DISPLAY    = 7'h5C;

    localparam logic KIND_PIXEL      = 1'b0;
    localparam logic KIND_FRAME_DONE = 1'b1;

    typedef struct packed {
        logic       clock_level;
        logic [7:0] bus_byte;
    } t_in_item;

    typedef struct packed {
        logic       result_kind;
        logic [7:0] pixel_x;
        logic [7:0] pixel_y;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_out_item;

    typedef struct packed {
        logic     advance;
        t_in_item item;
    } t_core_req;

    typedef struct packed {
        logic      valid;
        t_out_item item;
    } t_core_rsp;

endpackage

/* rtl/core/lcd_bus_pixel_decoder.sv */
// Top level of the LCD bus pixel decoder: input register, decode core and result register.
// The block takes one bus sample per cycle with no gaps while o_stall is low. A result is
// registered: the sample waits in the input register, and its decode against the current
// decoder state then lands in the result register once that register is free.
// Only samples that show a rising bus clock give a result: a frame-done request for a command
// that follows data in line-latch or display mode, or a pixel write when a nibble triple
// completes inside the frame.
// Samples that give no result still pass through and update the decoder state. A stall on the
// result side holds the result register and, once the input register is also full, stalls
// the input side.
module lcd_bus_pixel_decoder #(
    parameter int FRAME_WIDTH  = 176,
    parameter int FRAME_HEIGHT = 208
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  lbpd_pkg::t_in_item   i_data,
    output logic                 o_stall,
    output logic                 o_valid,
    output lbpd_pkg::t_out_item  o_data,
    input  logic                 i_stall
);
    import lbpd_pkg::*;

    logic      r_in_valid;
    t_in_item  r_in;
    logic      r_out_valid;
    t_out_item r_out;
    logic      out_free;
    t_core_req core_req;
    t_core_rsp core_rsp;

    assign out_free = !r_out_valid || !i_stall;
    assign o_stall  = r_in_valid && !out_free;
    assign o_valid  = r_out_valid;
    assign o_data   = r_out;

    assign core_req.advance = r_in_valid && out_free;
    assign core_req.item    = r_in;

    lbpd_core #(
        .FRAME_WIDTH  (FRAME_WIDTH),
        .FRAME_HEIGHT (FRAME_HEIGHT)
    ) u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (core_req),
        .o_rsp   (core_rsp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (!o_stall) begin
                r_in_valid <= i_valid;
            end
            if (out_free) begin
                r_out_valid <= core_req.advance && core_rsp.valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_stall && i_valid) begin
            r_in <= i_data;
        end
        if (core_req.advance && core_rsp.valid) begin
            r_out <= core_rsp.item;
        end
    end

endmodule

/* rtl/core/lbpd_core.sv */
// Decoder state and the single-pass decode of one bus sample into at most one result.
module lbpd_core #(
    parameter int FRAME_WIDTH  = 176,
    parameter int FRAME_HEIGHT = 208
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  lbpd_pkg::t_core_req  i_req,
    output lbpd_pkg::t_core_rsp  o_rsp
);
    import lbpd_pkg::*;

    localparam logic [8:0] WIDTH_LIMIT  = 9'(FRAME_WIDTH);
    localparam logic [8:0] HEIGHT_LIMIT = 9'(FRAME_HEIGHT);

    logic       r_prev_clock, n_prev_clock;
    t_mode      r_mode, n_mode;
    logic       r_words_seen, n_words_seen;
    logic [6:0] r_row_offset, n_row_offset;
    logic [7:0] r_held, n_held;
    logic [1:0] r_phase, n_phase;
    logic [7:0] r_column, n_column;
    logic [7:0] r_row_count, n_row_count;
    logic       r_parity, n_parity;
    logic       r_pred_red, n_pred_red;
    logic       r_pred_green, n_pred_green;
    logic       r_pred_blue, n_pred_blue;

    logic       rising;
    logic [7:0] data;
    logic [3:0] nib_hi, nib_lo, nib0, nib1, nib2;
    logic       pixel_done;
    logic [8:0] row_sum;
    logic       visible;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_clock <= 1'b0;
            r_mode       <= MODE_IDLE;
            r_words_seen <= 1'b0;
            r_row_offset <= '0;
            r_held       <= '0;
            r_phase      <= '0;
            r_column     <= '0;
            r_row_count  <= '0;
            r_parity     <= 1'b0;
            r_pred_red   <= 1'b0;
            r_pred_green <= 1'b0;
            r_pred_blue  <= 1'b0;
        end else begin
            r_prev_clock <= n_prev_clock;
            r_mode       <= n_mode;
            r_words_seen <= n_words_seen;
            r_row_offset <= n_row_offset;
            r_held       <= n_held;
            r_phase      <= n_phase;
            r_column     <= n_column;
            r_row_count  <= n_row_count;
            r_parity     <= n_parity;
            r_pred_red   <= n_pred_red;
            r_pred_green <= n_pred_green;
            r_pred_blue  <= n_pred_blue;
        end
    end

    always_comb begin
        n_prev_clock = r_prev_clock;
        n_mode       = r_mode;
        n_words_seen = r_words_seen;
        n_row_offset = r_row_offset;
        n_held       = r_held;
        n_phase      = r_phase;
        n_column     = r_column;
        n_row_count  = r_row_count;
        n_parity     = r_parity;
        n_pred_red   = r_pred_red;
        n_pred_green = r_pred_green;
        n_pred_blue  = r_pred_blue;

        data       = i_req.item.bus_byte;
        rising     = !r_prev_clock && i_req.item.clock_level;
        nib_hi     = data[7:4];
        nib_lo     = data[3:0];
        nib0       = '0;
        nib1       = '0;
        nib2       = '0;
        pixel_done = 1'b0;
        row_sum    = {2'b00, r_row_offset} + {1'b0, r_row_count};
        visible    = (row_sum < HEIGHT_LIMIT) && ({1'b0, r_column} < WIDTH_LIMIT);

        o_rsp = '0;

        if (i_req.advance) begin
            n_prev_clock = i_req.item.clock_level;
        end

        if (i_req.advance && rising) begin
            if (!data[7]) begin
                if (r_words_seen) begin
                    o_rsp.valid            = 1'b1;
                    o_rsp.item.result_kind = KIND_FRAME_DONE;
                end
                n_words_seen = 1'b0;
                if (data[6:0] == CMD_LINE_LATCH) begin
                    n_mode       = MODE_LATCH;
                    n_held       = '0;
                    n_phase      = '0;
                    n_column     = '0;
                    n_row_count  = '0;
                    n_parity     = 1'b0;
                    n_pred_red   = 1'b0;
                    n_pred_green = 1'b0;
                    n_pred_blue  = 1'b0;
                end else if (data[6:0] == CMD_DISPLAY) begin
                    n_mode = MODE_DISPLAY;
                end else begin
                    n_mode = MODE_IDLE;
                end
            end else begin
                unique case (r_mode)
                    MODE_LATCH: begin
                        if (!r_words_seen) begin
                            n_row_offset = data[6:0];
                        end
                        n_words_seen = 1'b1;
                    end
                    MODE_DISPLAY: begin
                        n_words_seen = 1'b1;
                        priority if (r_phase == 2'd0) begin
                            n_held  = data;
                            n_phase = 2'd2;
                        end else if (r_phase == 2'd1) begin
                            nib0       = r_held[3:0];
                            nib1       = nib_hi;
                            nib2       = nib_lo;
                            pixel_done = 1'b1;
                            n_held     = '0;
                            n_phase    = 2'd0;
                        end else begin
                            nib0       = r_held[7:4];
                            nib1       = r_held[3:0];
                            nib2       = nib_hi;
                            pixel_done = 1'b1;
                            n_held     = {4'h0, nib_lo};
                            n_phase    = 2'd1;
                        end
                    end
                    MODE_IDLE: begin
                    end
                    default: begin
                    end
                endcase
            end
        end

        if (pixel_done) begin
            if (!r_parity) begin
                n_pred_green = nib1[3];
            end else begin
                n_pred_red  = nib0[3];
                n_pred_blue = nib2[3];
            end
            if (visible) begin
                o_rsp.valid            = 1'b1;
                o_rsp.item.result_kind = KIND_PIXEL;
                o_rsp.item.pixel_x     = r_column;
                o_rsp.item.pixel_y     = row_sum[7:0];
                o_rsp.item.red         = {n_pred_red, nib0[2:0], 4'h0};
                o_rsp.item.green       = {n_pred_green, nib1[2:0], 4'h0};
                o_rsp.item.blue        = {n_pred_blue, nib2[2:0], 4'h0};
            end
            n_parity = !r_parity;
            if (({1'b0, r_column} + 9'd1) >= WIDTH_LIMIT) begin
                n_column = '0;
                if (r_row_count != 8'hFF) begin
                    n_row_count = r_row_count + 8'd1;
                end
            end else begin
                n_column = r_column + 8'd1;
            end
        end
    end

endmodule

/* bench/lcd_bus_pixel_decoder_tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench of the LCD bus pixel decoder, with its own decode predictor.
module lcd_bus_pixel_decoder_tb;
    import lbpd_pkg::*;

    localparam int FRAME_WIDTH  = 176;
    localparam int FRAME_HEIGHT = 208;
    localparam int STALL_LIMIT  = 2000;
    localparam int HOLD_CYCLES  = 300;
    localparam int PLAN_ROWS    = 25;
    localparam int RANDOM_BYTES = 450;
    localparam int LONG_BYTES   = 120;
    localparam t_out_item NO_RES = '0;
    localparam t_out_item FRAME_DONE_RES = t_out_item'({KIND_FRAME_DONE, 40'd0});

    typedef struct {
        t_in_item  item;
        logic      typed;
        int        count;
        t_out_item res;
    } t_plan_row;

    logic      i_clk;
    logic      i_rst_n;
    logic      i_valid;
    t_in_item  i_data;
    logic      o_stall;
    logic      o_valid;
    t_out_item o_data;
    logic      i_stall;

    lcd_bus_pixel_decoder #(
        .FRAME_WIDTH  (FRAME_WIDTH),
        .FRAME_HEIGHT (FRAME_HEIGHT)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_data  (i_data),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .o_data  (o_data),
        .i_stall (i_stall)
    );

    logic       prev_clock;
    t_mode      bus_mode;
    logic       words_seen;
    logic [6:0] row_offset;
    logic [7:0] held_nibbles;
    logic [1:0] nibble_phase;
    logic [7:0] pixel_column;
    logic [7:0] row_count;
    logic       odd_pixel;
    logic       red_pred;
    logic       green_pred;
    logic       blue_pred;

    t_out_item pending_results[$];
    t_plan_row plan[PLAN_ROWS];
    t_out_item want;
    logic      quiet;
    logic      hold_now;
    int        bytes_taken;
    int        pixels_seen;
    int        frames_seen;
    int        mismatches;
    int        idle_cycles;

    always begin
        i_clk = 1'b1;
        #6;
        i_clk = 1'b0;
        #6;
    end

    task automatic clear_decoder();
        held_nibbles = '0;
        nibble_phase = '0;
        pixel_column = '0;
        row_count    = '0;
        odd_pixel    = 1'b0;
        red_pred     = 1'b0;
        green_pred   = 1'b0;
        blue_pred    = 1'b0;
    endtask

    task automatic feed_nibble(input logic [3:0] nib, inout int n, inout t_out_item r);
        logic [3:0] n0;
        logic [3:0] n1;
        int         y;
        if (nibble_phase < 2'd2) begin
            held_nibbles = {held_nibbles[3:0], nib};
            nibble_phase = nibble_phase + 2'd1;
        end else begin
            n0 = held_nibbles[7:4];
            n1 = held_nibbles[3:0];
            held_nibbles = '0;
            nibble_phase = '0;
            if (!odd_pixel) begin
                green_pred = n1[3];
            end else begin
                red_pred  = n0[3];
                blue_pred = nib[3];
            end
            y = int'(row_offset) + int'(row_count);
            if (y < FRAME_HEIGHT && int'(pixel_column) < FRAME_WIDTH) begin
                n++;
                r.result_kind = KIND_PIXEL;
                r.pixel_x     = pixel_column;
                r.pixel_y     = y[7:0];
                r.red         = {red_pred, n0[2:0], 4'h0};
                r.green       = {green_pred, n1[2:0], 4'h0};
                r.blue        = {blue_pred, nib[2:0], 4'h0};
            end
            odd_pixel = ~odd_pixel;
            if (int'(pixel_column) + 1 >= FRAME_WIDTH) begin
                pixel_column = '0;
                if (row_count != 8'hFF) begin
                    row_count = row_count + 8'd1;
                end
            end else begin
                pixel_column = pixel_column + 8'd1;
            end
        end
    endtask

    task automatic decode_sample(input t_in_item it, output int n, output t_out_item r);
        logic rising;
        n = 0;
        r = '0;
        rising = !prev_clock && it.clock_level;
        prev_clock = it.clock_level;
        if (rising && !it.bus_byte[7]) begin
            bytes_taken++;
            if (words_seen) begin
                n = 1;
                r.result_kind = KIND_FRAME_DONE;
            end
            words_seen = 1'b0;
            if (it.bus_byte[6:0] == CMD_LINE_LATCH) begin
                bus_mode = MODE_LATCH;
                clear_decoder();
            end else if (it.bus_byte[6:0] == CMD_DISPLAY) begin
                bus_mode = MODE_DISPLAY;
            end else begin
                bus_mode = MODE_IDLE;
            end
        end else if (rising && bus_mode == MODE_LATCH) begin
            bytes_taken++;
            if (!words_seen) begin
                row_offset = it.bus_byte[6:0];
            end
            words_seen = 1'b1;
        end else if (rising && bus_mode == MODE_DISPLAY) begin
            bytes_taken++;
            words_seen = 1'b1;
            feed_nibble(it.bus_byte[7:4], n, r);
            feed_nibble(it.bus_byte[3:0], n, r);
        end
    endtask

    task automatic send_item(input t_in_item it, input logic typed, input int tn,
                             input t_out_item tr);
        int        gap;
        int        n;
        t_out_item r;
        gap = 0;
        if (!quiet && $urandom_range(0, 9) == 0) begin
            gap = $urandom_range(1, 15);
        end
        repeat (gap) begin
            @(negedge i_clk);
            i_valid <= 1'b0;
        end
        @(negedge i_clk);
        i_valid <= 1'b1;
        i_data  <= it;
        do @(posedge i_clk); while (o_stall);
        decode_sample(it, n, r);
        if (typed) begin
            n = tn;
            r = tr;
        end
        if (n > 0) begin
            pending_results.push_back(r);
        end
    endtask

    task automatic send_byte(input logic [7:0] b);
        send_item(t_in_item'({1'b0, 8'($urandom)}), 1'b0, 0, NO_RES);
        send_item(t_in_item'({1'b1, b}), 1'b0, 0, NO_RES);
    endtask

    task automatic send_frame(input int nbytes);
        send_byte({1'b0, CMD_LINE_LATCH});
        send_byte({1'b1, 7'($urandom_range(0, 127))});
        repeat ($urandom_range(0, 2)) send_byte({1'b1, 7'($urandom_range(0, 127))});
        send_byte({1'b0, CMD_DISPLAY});
        repeat (nbytes) send_byte({1'b1, 7'($urandom_range(0, 127))});
    endtask

    // Receiver side: random stall bursts, and one long hold-off that backs up the block.
    initial begin
        i_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_now) begin
                i_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                hold_now = 1'b0;
                i_stall <= 1'b0;
            end else if (!quiet && $urandom_range(0, 7) == 0) begin
                i_stall <= 1'b1;
                repeat ($urandom_range(1, 15)) @(negedge i_clk);
                i_stall <= 1'b0;
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("unexpected result: kind %0d x %0d y %0d rgb %h %h %h",
                             o_data.result_kind, o_data.pixel_x, o_data.pixel_y,
                             o_data.red, o_data.green, o_data.blue);
                end
            end else begin
                want = pending_results.pop_front();
                if (o_data.result_kind !== want.result_kind || o_data.pixel_x !== want.pixel_x
                    || o_data.pixel_y !== want.pixel_y || o_data.red !== want.red
                    || o_data.green !== want.green || o_data.blue !== want.blue) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("mismatch: expected kind %0d x %0d y %0d rgb %h %h %h",
                                 want.result_kind, want.pixel_x, want.pixel_y,
                                 want.red, want.green, want.blue);
                        $display("          actual   kind %0d x %0d y %0d rgb %h %h %h",
                                 o_data.result_kind, o_data.pixel_x, o_data.pixel_y,
                                 o_data.red, o_data.green, o_data.blue);
                    end
                end
            end
            if (o_data.result_kind == KIND_FRAME_DONE) begin
                frames_seen++;
            end else begin
                pixels_seen++;
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= STALL_LIMIT) begin
            $display("timeout: no request moved for %0d cycles", STALL_LIMIT);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial begin
        int base;
        i_rst_n     = 1'b0;
        i_valid     = 1'b0;
        i_data      = '0;
        quiet       = 1'b0;
        hold_now    = 1'b0;
        bytes_taken = 0;
        pixels_seen = 0;
        frames_seen = 0;
        mismatches  = 0;
        idle_cycles = 0;
        prev_clock  = 1'b0;
        bus_mode    = MODE_IDLE;
        words_seen  = 1'b0;
        row_offset  = '0;
        clear_decoder();

        plan[0]  = '{t_in_item'({1'b1, 8'h75}), 1'b1, 0, NO_RES};
        plan[1]  = '{t_in_item'({1'b1, 8'hFF}), 1'b1, 0, NO_RES};
        plan[2]  = '{t_in_item'({1'b0, 8'h80}), 1'b0, 0, NO_RES};
        plan[3]  = '{t_in_item'({1'b1, 8'hFF}), 1'b1, 0, NO_RES};
        plan[4]  = '{t_in_item'({1'b0, 8'h00}), 1'b0, 0, NO_RES};
        plan[5]  = '{t_in_item'({1'b1, 8'h80}), 1'b0, 0, NO_RES};
        plan[6]  = '{t_in_item'({1'b0, 8'hFF}), 1'b0, 0, NO_RES};
        plan[7]  = '{t_in_item'({1'b1, 8'h5C}), 1'b1, 1, FRAME_DONE_RES};
        plan[8]  = '{t_in_item'({1'b0, 8'h5C}), 1'b0, 0, NO_RES};
        plan[9]  = '{t_in_item'({1'b1, 8'hFF}), 1'b0, 0, NO_RES};
        plan[10] = '{t_in_item'({1'b0, 8'h00}), 1'b0, 0, NO_RES};
        plan[11] = '{t_in_item'({1'b1, 8'hF0}), 1'b1, 1,
                     t_out_item'({KIND_PIXEL, 8'd0, 8'd127, 8'h70, 8'hF0, 8'h70})};
        plan[12] = '{t_in_item'({1'b0, 8'h7F}), 1'b0, 0, NO_RES};
        plan[13] = '{t_in_item'({1'b1, 8'h80}), 1'b0, 0, NO_RES};
        plan[14] = '{t_in_item'({1'b0, 8'h80}), 1'b0, 0, NO_RES};
        plan[15] = '{t_in_item'({1'b1, 8'h00}), 1'b1, 1, FRAME_DONE_RES};
        plan[16] = '{t_in_item'({1'b0, 8'h00}), 1'b0, 0, NO_RES};
        plan[17] = '{t_in_item'({1'b1, 8'hAA}), 1'b0, 0, NO_RES};
        plan[18] = '{t_in_item'({1'b0, 8'h55}), 1'b0, 0, NO_RES};
        plan[19] = '{t_in_item'({1'b1, 8'h7F}), 1'b0, 0, NO_RES};
        plan[20] = '{t_in_item'({1'b0, 8'h5C}), 1'b0, 0, NO_RES};
        plan[21] = '{t_in_item'({1'b1, 8'h5C}), 1'b0, 0, NO_RES};
        plan[22] = '{t_in_item'({1'b0, 8'h00}), 1'b0, 0, NO_RES};
        plan[23] = '{t_in_item'({1'b1, 8'hDC}), 1'b0, 0, NO_RES};
        plan[24] = '{t_in_item'({1'b0, 8'hFF}), 1'b0, 0, NO_RES};

        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (int k = 0; k < PLAN_ROWS; k++) begin
            send_item(plan[k].item, plan[k].typed, plan[k].count, plan[k].res);
        end

        // The first random frame runs while the receiver holds off.
        base = bytes_taken;
        hold_now = 1'b1;
        send_frame(60);
        while (bytes_taken - base < RANDOM_BYTES) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5: begin
                    send_frame($urandom_range(1, 40));
                end
                6: begin
                    repeat ($urandom_range(1, 12)) begin
                        send_item(t_in_item'(9'($urandom)), 1'b0, 0, NO_RES);
                    end
                end
                7: begin
                    send_byte({1'b0, 7'($urandom_range(0, 127))});
                    repeat ($urandom_range(1, 6)) send_byte({1'b1, 7'($urandom_range(0, 127))});
                end
                8: begin
                    send_byte({1'b0, CMD_DISPLAY});
                    repeat ($urandom_range(1, 20)) send_byte({1'b1, 7'($urandom_range(0, 127))});
                end
                default: begin
                    repeat ($urandom_range(2, 6)) begin
                        send_item(t_in_item'({1'b1, 8'($urandom)}), 1'b0, 0, NO_RES);
                    end
                end
            endcase
        end

        // The last frame runs with no idling on either side.
        quiet = 1'b1;
        send_frame(LONG_BYTES);
        send_byte(8'h00);

        @(negedge i_clk);
        i_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        $display("Decoded %0d bus bytes into %0d pixel writes and %0d frame-done results,",
                 bytes_taken, pixels_seen, frames_seen);
        $display("including a long receiver hold-off and a closing stretch at full rate.");
        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("%0d mismatches, %0d results never arrived",
                     mismatches, pending_results.size());
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

/* lcd_bus_pixel_decoder.f */
rtl/core/lbpd_pkg.sv
rtl/core/lbpd_core.sv
rtl/core/lcd_bus_pixel_decoder.sv
bench/lcd_bus_pixel_decoder_tb.sv
